/* hw/rtl/nlp_pkg.sv */
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared types for the next lexicographic permutation block: controller
// states, the command bundle to the datapath and the status bundle back.
// ----------------------------------------------------------------------------
package nlp_pkg;

  // Width of the element fields on both channels
  localparam int VALUE_W = 16;

  typedef enum logic [2:0] {
    S_LOAD,
    S_REWIND,
    S_SCAN,
    S_SEARCH,
    S_SWAP_A,
    S_SWAP_B,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;    // take input transfers
    logic rewind;      // restart the store walk from the last element
    logic step;        // issue the next read of the walk
    logic search;      // walk looks for the swap partner
    logic take_pivot;  // capture pivot from the read data
    logic no_pivot;    // no ascent: reverse the whole run
    logic take_swap;   // capture swap partner from the read data
    logic wr_pivot;    // write partner value into the pivot slot
    logic wr_swap;     // write pivot value into the partner slot
    logic emit_rd;     // read the first result element
    logic emit_ld;     // load the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_in;     // marked input item offered
    logic scan_hit;    // pivot found
    logic scan_end;    // walk reached the first element without an ascent
    logic srch_hit;    // swap partner found
    logic emit_last;   // element being emitted is the final one
    logic out_free;    // output register can take a new element
  } dp_status_t;

endpackage

/* hw/rtl/nlp_if.sv */
// ----------------------------------------------------------------------------
// nlp_if
// Valid/ready channels of the permutation block: element input and
// permuted element output.
// ----------------------------------------------------------------------------
interface nlp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [nlp_pkg::VALUE_W-1:0] value;
  logic                                is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface nlp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [nlp_pkg::VALUE_W-1:0] value_res;
  logic                                last_out;
  logic                                dropped;

  modport source (output valid, output value_res, output last_out, output dropped,
                  input ready);
  modport sink   (input valid, input value_res, input last_out, input dropped,
                  output ready);
endinterface

/* hw/rtl/nlp_ram.sv */
// ----------------------------------------------------------------------------
// nlp_ram
// Generic single-write, single-read RAM with registered read data that
// holds while no read is issued.
// ----------------------------------------------------------------------------
module nlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/nlp_ctrl.sv */
// ----------------------------------------------------------------------------
// nlp_ctrl
// Sequencer of the permutation block: load, pivot scan, partner search,
// swap and emit.
// ----------------------------------------------------------------------------
module nlp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  nlp_pkg::dp_status_t status,
  output nlp_pkg::dp_cmd_t    cmd
);
  import nlp_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.in_ready = 1'b1;
        if (status.last_in) begin
          state_next = S_REWIND;
        end
      end
      S_REWIND: begin
        cmd.rewind = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_hit) begin
          cmd.take_pivot = 1'b1;
          cmd.rewind     = 1'b1;
          state_next     = S_SEARCH;
        end else if (status.scan_end) begin
          cmd.no_pivot = 1'b1;
          state_next   = S_EMIT_RD;
        end
      end
      S_SEARCH: begin
        cmd.step   = 1'b1;
        cmd.search = 1'b1;
        if (status.srch_hit) begin
          cmd.take_swap = 1'b1;
          state_next    = S_SWAP_A;
        end
      end
      S_SWAP_A: begin
        cmd.wr_pivot = 1'b1;
        state_next   = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.wr_swap = 1'b1;
        state_next  = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status.out_free) begin
          cmd.emit_ld = 1'b1;
          if (status.emit_last) begin
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

/* hw/rtl/nlp_dp.sv */
// ----------------------------------------------------------------------------
// nlp_dp
// Datapath of the permutation block: element store, walk pointer with
// compare, pivot and partner registers, reversed-tail read addressing and
// the output register.
// ----------------------------------------------------------------------------
module nlp_dp #(
  parameter int MAX_LEN    = 32,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  nlp_in_if.sink              items,
  nlp_out_if.source           results,
  input  nlp_pkg::dp_cmd_t    cmd,
  output nlp_pkg::dp_status_t status
);
  import nlp_pkg::*;

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int XW = CW + 1;
  localparam int WW = ELEM_WIDTH + VALUE_W;

  // Control registers
  logic [CW-1:0] count;
  logic          ovf;
  logic [IW-1:0] ptr;
  logic          issued_all;
  logic          rd_vld;
  logic          have_prev;
  logic [CW-1:0] k;
  logic          out_vld;

  // Payload registers
  logic [IW-1:0]         rd_idx;
  logic [ELEM_WIDTH-1:0] prev;
  logic [IW-1:0]         piv_idx;
  logic [ELEM_WIDTH-1:0] piv_val;
  logic [IW-1:0]         sw_idx;
  logic [ELEM_WIDTH-1:0] sw_val;
  logic [CW-1:0]         lo;
  logic [VALUE_W-1:0]    out_value;
  logic                  out_last;
  logic                  out_dropped;

  // Store ports
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [ELEM_WIDTH-1:0] rd_data;

  logic                  in_fire;
  logic                  has_room;
  logic                  issue;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         ek;
  logic [XW-1:0]         rev;
  logic [IW-1:0]         emit_addr;
  logic                  emit_read;
  logic [WW-1:0]         in_wide;
  logic [WW-1:0]         out_wide;

  assign items.ready = cmd.in_ready;
  assign in_fire     = items.valid & cmd.in_ready;
  assign has_room    = count < CW'(MAX_LEN);
  assign in_wide     = {{ELEM_WIDTH{1'b0}}, items.value};
  assign out_wide    = {{VALUE_W{1'b0}}, rd_data};
  assign cnt_m1      = count - CW'(1);
  assign issue       = cmd.step & ~issued_all;

  // Result order: head in place, tail after the pivot read backwards
  assign ek        = cmd.emit_ld ? k + CW'(1) : k;
  assign rev       = XW'(count) + XW'(lo) - XW'(ek) - XW'(1);
  assign emit_addr = (ek < lo) ? ek[IW-1:0] : rev[IW-1:0];
  assign emit_read = cmd.emit_rd | (cmd.emit_ld & ~status.emit_last);

  assign rd_en   = issue | emit_read;
  assign rd_addr = issue ? ptr : emit_addr;

  // Store write select: load, then the two halves of the swap
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IW-1:0];
    wr_data = in_wide[ELEM_WIDTH-1:0];
    if (in_fire && has_room) begin
      wr_en = 1'b1;
    end else if (cmd.wr_pivot) begin
      wr_en   = 1'b1;
      wr_addr = piv_idx;
      wr_data = sw_val;
    end else if (cmd.wr_swap) begin
      wr_en   = 1'b1;
      wr_addr = sw_idx;
      wr_data = piv_val;
    end
  end

  // Status back to the controller
  always_comb begin
    status           = '0;
    status.last_in   = items.valid & items.is_last;
    status.scan_hit  = rd_vld & have_prev & ($signed(rd_data) < $signed(prev));
    status.scan_end  = rd_vld & (rd_idx == '0) & ~status.scan_hit;
    status.srch_hit  = rd_vld & ($signed(rd_data) > $signed(piv_val));
    status.emit_last = (k == cnt_m1);
    status.out_free  = ~out_vld | results.ready;
  end

  // Count, overflow flag, walk control, emit index and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf        <= 1'b0;
      ptr        <= '0;
      issued_all <= 1'b0;
      rd_vld     <= 1'b0;
      have_prev  <= 1'b0;
      k          <= '0;
      out_vld    <= 1'b0;
    end else begin
      if (in_fire) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.emit_ld && status.emit_last) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      rd_vld <= issue & ~cmd.rewind;
      if (cmd.rewind) begin
        ptr        <= cnt_m1[IW-1:0];
        issued_all <= 1'b0;
        have_prev  <= 1'b0;
        k          <= '0;
      end else if (cmd.step) begin
        if (issue) begin
          ptr        <= ptr - IW'(1);
          issued_all <= (ptr == '0);
        end
        if (rd_vld) begin
          have_prev <= 1'b1;
        end
      end
      if (cmd.emit_ld) begin
        k       <= k + CW'(1);
        out_vld <= 1'b1;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // Walk data, pivot and partner capture, output payload
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= ptr;
    end
    if (cmd.step && rd_vld) begin
      prev <= rd_data;
    end
    if (cmd.take_pivot) begin
      piv_idx <= rd_idx;
      piv_val <= rd_data;
      lo      <= CW'(rd_idx) + CW'(1);
    end else if (cmd.no_pivot) begin
      lo <= '0;
    end
    if (cmd.take_swap) begin
      sw_idx <= rd_idx;
      sw_val <= rd_data;
    end
    if (cmd.emit_ld) begin
      out_value   <= out_wide[VALUE_W-1:0];
      out_last    <= status.emit_last;
      out_dropped <= ovf;
    end
  end

  assign results.valid     = out_vld;
  assign results.value_res = $signed(out_value);
  assign results.last_out  = out_last;
  assign results.dropped   = out_dropped;

  nlp_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Store fill never passes its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LEN))
    else $error("element count beyond store depth");

  // Partner search ends before it reaches the pivot slot
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && cmd.search && rd_vld) |-> (rd_idx > piv_idx))
    else $error("partner search walked onto the pivot");

  // Result reads stay inside the loaded run
  a_emit_addr: assert property (@(posedge clk) disable iff (rst)
    (emit_read && !issue) |-> (CW'(emit_addr) < count))
    else $error("result read outside the loaded run");

endmodule

/* hw/rtl/next_lexicographic_permutation.sv */
// ----------------------------------------------------------------------------
// next_lexicographic_permutation
// Loads a run of signed elements and returns its next lexicographic
// permutation, wrapping from the last order back to ascending.
// ----------------------------------------------------------------------------
// Usage:
//   items   : one element per transfer; is_last closes the run. Elements past
//             MAX_LEN are discarded and every result of that run has dropped.
//   results : one transfer per stored element, in order, last_out on the
//             final one. Items are not taken while a run is being worked on.
//   Sequence of a run: loading takes one element per cycle while items are
//   offered; a rewind state follows the marked transfer; the pivot scan
//   reads the store backwards, one entry a cycle; the partner search walks
//   the tail again from the last element; the swap is two store writes; the
//   results leave at one per cycle, while the receiver keeps ready high,
//   after a read start state. The scan, the search and the result reads
//   share the single store read port.
//   A stalled receiver holds the output register; result reads wait with it.
//   The last result may wait in the output register while the next run loads.
//   Reset (rst, synchronous) empties the run and clears the overflow flag;
//   store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation #(
  parameter int MAX_LEN    = 32,
  parameter int ELEM_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  nlp_in_if.sink    items,
  nlp_out_if.source results
);
  import nlp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  nlp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  nlp_dp #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cmd     (cmd),
    .status  (status)
  );

endmodule
